// File: rtl/olst_pkg.sv
// Shared types and codes for the ordered list store.
// Used by the cell, the sequencer, the top level and the port checker.
package olst_pkg;

	// command codes on the input channel
	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_READ_AT    = 3'd3,
		CMD_INSERT_AT  = 3'd4,
		CMD_MIN_MAX    = 3'd5
	} olst_cmd_t;

	// status codes on the result channel
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} olst_status_t;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} olst_state_t;

	// shift controls broadcast to every cell of the row
	typedef struct packed {
		logic ins;	// open a gap at the insert position and load the new item
		logic pop;	// move every item one place towards the front
	} olst_shift_t;

endpackage

// File: rtl/olst_cell.sv
// One storage cell of the shifting row; position IDX in the sequence.
// Depends on olst_pkg for the shift control struct.
module olst_cell import olst_pkg::*; #(
	parameter int DEPTH     = 16,
	parameter int ITEM_BITS = 32,
	parameter int IDX       = 0
) (
	input  logic                          clk,
	input  olst_shift_t                   shift,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ins_pos,
	input  logic [ITEM_BITS-1:0]          new_item,
	input  logic [ITEM_BITS-1:0]          from_front,
	input  logic [ITEM_BITS-1:0]          from_back,
	output logic [ITEM_BITS-1:0]          data_q
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [IW-1:0] MY_POS = IW'(IDX);

	// load, take from the front neighbour, take from the back neighbour, or hold
	always_ff @(posedge clk) begin
		if (shift.ins) begin
			if (MY_POS == ins_pos)
				data_q <= new_item;
			else if (MY_POS > ins_pos)
				data_q <= from_front;
		end else if (shift.pop) begin
			data_q <= from_back;
		end
	end

endmodule

// File: rtl/olst_ctrl.sv
// Command sequencer for the ordered list store: occupancy, status decisions,
// min/max scan over the cell row and the result register. Depends on olst_pkg.
module olst_ctrl import olst_pkg::*; #(
	parameter int DEPTH     = 16,
	parameter int ITEM_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    command,
	input  logic [4:0]                    position,
	input  logic signed [31:0]            value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic signed [31:0]            item_out,
	output logic signed [31:0]            largest,
	output logic signed [31:0]            smallest,
	output logic [4:0]                    fill_count,
	output olst_shift_t                   shift,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ins_pos,
	output logic [ITEM_BITS-1:0]          new_item,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_idx,
	input  logic [ITEM_BITS-1:0]          rd_data
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 5) ? CW : 5;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	// sign-extend or truncate an item to the 32-bit result fields
	function automatic logic [31:0] to_port(input logic [ITEM_BITS-1:0] x);
		logic signed [63:0] w;
		w = 64'(signed'(x));
		return w[31:0];
	endfunction

	olst_state_t            state_q;
	logic [2:0]             cmd_q;
	logic [4:0]             pos_q;
	logic [ITEM_BITS-1:0]   val_q;
	logic [CW-1:0]          occ_q;
	logic [IW-1:0]          scan_q;
	logic [ITEM_BITS-1:0]   max_q;
	logic [ITEM_BITS-1:0]   min_q;

	logic                   out_valid_q;
	olst_status_t           status_q;
	logic [ITEM_BITS-1:0]   item_q;
	logic [ITEM_BITS-1:0]   big_q;
	logic [ITEM_BITS-1:0]   small_q;
	logic [4:0]             fill_q;

	logic                   out_free;
	logic                   emit;
	logic                   go_scan;
	logic                   scan_last;
	olst_shift_t            shift_req;
	olst_status_t           res_st;
	logic [ITEM_BITS-1:0]   res_item;
	logic [CW-1:0]          occ_d;
	logic [PW-1:0]          pos_ext;
	logic [PW-1:0]          occ_ext;
	logic [PW-1:0]          tgt;
	logic signed [63:0]     val_wide;

	assign in_ready   = (state_q == S_IDLE);
	assign out_free   = !out_valid_q || out_ready;
	assign pos_ext    = PW'(pos_q);
	assign occ_ext    = PW'(occ_q);
	assign val_wide   = 64'(value);
	assign new_item   = val_q;
	assign scan_last  = ((CW'(scan_q) + CW'(1)) == occ_q);

	// decide the outcome of the held command
	always_comb begin
		shift_req = '0;
		ins_pos   = '0;
		rd_idx    = '0;
		res_st    = ST_OK;
		res_item  = '0;
		occ_d     = occ_q;
		go_scan   = 1'b0;
		emit      = 1'b0;
		tgt       = '0;
		case (state_q)
			S_EXEC: begin
				case (cmd_q)
					CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
						if (cmd_q == CMD_PUSH_FRONT)
							tgt = '0;
						else if (cmd_q == CMD_PUSH_BACK)
							tgt = occ_ext;
						else
							tgt = pos_ext;
						if (occ_q == FULL_CNT) begin
							res_st = ST_FULL;
						end else if (tgt > occ_ext) begin
							res_st = ST_RANGE;
						end else begin
							shift_req.ins = 1'b1;
							ins_pos       = tgt[IW-1:0];
							occ_d         = CW'(occ_q + CW'(1));
						end
					end
					CMD_POP_FRONT: begin
						if (occ_q == '0) begin
							res_st = ST_EMPTY;
						end else begin
							res_item      = rd_data;
							shift_req.pop = 1'b1;
							occ_d         = CW'(occ_q - CW'(1));
						end
					end
					CMD_READ_AT: begin
						if (pos_ext >= occ_ext) begin
							res_st = ST_RANGE;
						end else begin
							rd_idx   = pos_ext[IW-1:0];
							res_item = rd_data;
						end
					end
					CMD_MIN_MAX: begin
						if (occ_q == '0)
							res_st = ST_EMPTY;
						else
							go_scan = 1'b1;
					end
					default: ;
				endcase
				emit = out_free && !go_scan;
			end
			S_SCAN: rd_idx = scan_q;
			S_DONE: emit = out_free;
			default: ;
		endcase
		shift.ins = shift_req.ins & emit;
		shift.pop = shift_req.pop & emit;
	end

	// sequencer, occupancy and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (emit)
				occ_q <= occ_d;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: begin
					if (go_scan)
						state_q <= S_SCAN;
					else if (emit)
						state_q <= S_IDLE;
				end
				S_SCAN: if (scan_last) state_q <= S_DONE;
				S_DONE: if (emit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// capture the command, walk the row for min/max, load the result fields
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= command;
			pos_q <= position;
			val_q <= val_wide[ITEM_BITS-1:0];
		end
		if (go_scan)
			scan_q <= '0;
		else if (state_q == S_SCAN)
			scan_q <= IW'(scan_q + IW'(1));
		if (state_q == S_SCAN) begin
			if (scan_q == '0 || $signed(rd_data) > $signed(max_q))
				max_q <= rd_data;
			if (scan_q == '0 || $signed(rd_data) < $signed(min_q))
				min_q <= rd_data;
		end
		if (emit) begin
			status_q <= res_st;
			item_q   <= res_item;
			big_q    <= (state_q == S_DONE) ? max_q : '0;
			small_q  <= (state_q == S_DONE) ? min_q : '0;
			fill_q   <= 5'(occ_d);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign item_out   = to_port(item_q);
	assign largest    = to_port(big_q);
	assign smallest   = to_port(small_q);
	assign fill_count = fill_q;

endmodule

// File: rtl/ordered_list_store.sv
// Top level of the ordered list store: a row of DEPTH shifting cells with
// the command sequencer. Depends on olst_pkg, olst_cell and olst_ctrl.
//
//   channel | direction | handshake            | payload
//   input   | in        | in_valid / in_ready  | command, position, value
//   result  | out       | out_valid / out_ready| status, item_out, largest, smallest, fill_count
//
// Push, pop, insert and read capture the command on transfer, then shift the cell row
// and load the result register in the execute state. Min max goes from the execute
// state to a scan that reads one cell a cycle through the shared read multiplexer,
// then loads the result in the done state. Reset clears occupancy, the sequencer and
// the result valid only; cell contents are never read before written. A held result
// stalls the next command in execute or done until the result transfer completes.
module ordered_list_store import olst_pkg::*; #(
	parameter int DEPTH     = 16,
	parameter int ITEM_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         command,
	input  logic [4:0]         position,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] item_out,
	output logic signed [31:0] largest,
	output logic signed [31:0] smallest,
	output logic [4:0]         fill_count
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	olst_shift_t          shift;
	logic [IW-1:0]        ins_pos;
	logic [IW-1:0]        rd_idx;
	logic [ITEM_BITS-1:0] new_item;
	logic [ITEM_BITS-1:0] rd_data;
	logic [ITEM_BITS-1:0] cell_q [DEPTH];

	olst_ctrl #(
		.DEPTH     (DEPTH),
		.ITEM_BITS (ITEM_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.item_out   (item_out),
		.largest    (largest),
		.smallest   (smallest),
		.fill_count (fill_count),
		.shift      (shift),
		.ins_pos    (ins_pos),
		.new_item   (new_item),
		.rd_idx     (rd_idx),
		.rd_data    (rd_data)
	);

	// build the row; the end cells take their own value as the missing neighbour
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ITEM_BITS-1:0] front_d;
		logic [ITEM_BITS-1:0] back_d;
		if (i == 0) begin : g_first
			assign front_d = cell_q[i];
		end else begin : g_mid_f
			assign front_d = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign back_d = cell_q[i];
		end else begin : g_mid_b
			assign back_d = cell_q[i+1];
		end
		olst_cell #(
			.DEPTH     (DEPTH),
			.ITEM_BITS (ITEM_BITS),
			.IDX       (i)
		) u_cell (
			.clk        (clk),
			.shift      (shift),
			.ins_pos    (ins_pos),
			.new_item   (new_item),
			.from_front (front_d),
			.from_back  (back_d),
			.data_q     (cell_q[i])
		);
	end

	// select one cell for pop, read and the min/max scan
	assign rd_data = cell_q[rd_idx];

endmodule

// File: rtl/olst_chk.sv
// Port-level checker for the ordered list store, bound to the top level.
// Depends on olst_pkg for the status codes.
module olst_chk import olst_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [2:0]         command,
	input logic [4:0]         position,
	input logic signed [31:0] value,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic signed [31:0] item_out,
	input logic signed [31:0] largest,
	input logic signed [31:0] smallest,
	input logic [4:0]         fill_count
);

	// a stalled result holds its status, item and fill count
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(item_out)
			&& $stable(fill_count))
		else $error("result changed while stalled");

	// an empty report leaves nothing stored
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> fill_count == 5'd0)
		else $error("empty status with non-zero fill count");

	// a full report shows a full row
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> fill_count == 5'(DEPTH))
		else $error("full status with fill count below depth");

	// a failed command carries no item
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> item_out == '0 && largest == '0 && smallest == '0)
		else $error("failed command returned item data");

endmodule

bind ordered_list_store olst_chk #(.DEPTH(DEPTH)) u_olst_chk (.*);

// File: bench/tb_ordered_list_store.sv
// Self-checking bench for ordered_list_store: directed and random command streams
// with random idling on both channels, each result checked against a local list model.
// Depends on olst_pkg and the ordered_list_store RTL.
module tb_ordered_list_store import olst_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROW_CELLS    = 16;
	localparam int RANDOM_ITEMS = 1600;
	localparam int IDLE_PCT     = 37;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int REPORT_MAX   = 10;

	// command codes the block does not decode
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	// traffic mixes for the random part
	localparam int MIX_FILL  = 0;
	localparam int MIX_DRAIN = 1;
	localparam int MIX_EVEN  = 2;

	typedef struct {
		olst_status_t       status;
		logic signed [31:0] item;
		logic signed [31:0] max_item;
		logic signed [31:0] min_item;
		logic [4:0]         fill;
	} list_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         command;
	logic [4:0]         position;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic signed [31:0] item_out;
	logic signed [31:0] largest;
	logic signed [31:0] smallest;
	logic [4:0]         fill_count;

	// list contents as the block should hold them, front at index 0
	logic signed [31:0] list_row[$];
	list_result_t       pending_results[$];
	int                 mismatches;
	int                 cycle_count;
	logic               steady;

	ordered_list_store i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.item_out   (item_out),
		.largest    (largest),
		.smallest   (smallest),
		.fill_count (fill_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Place an item so that it lands at pos; fullness is checked before the position.
	function automatic olst_status_t list_place(int pos, logic signed [31:0] val);
		if (list_row.size() >= ROW_CELLS)
			return ST_FULL;
		if (pos > list_row.size())
			return ST_RANGE;
		list_row.insert(pos, val);
		return ST_OK;
	endfunction

	// Apply one command to the list and return the result it should produce.
	function automatic list_result_t list_apply(logic [2:0] cmd, logic [4:0] pos,
			logic signed [31:0] val);
		list_result_t r;
		r.status   = ST_OK;
		r.item     = '0;
		r.max_item = '0;
		r.min_item = '0;
		case (cmd)
			CMD_PUSH_FRONT: r.status = list_place(0, val);
			CMD_PUSH_BACK:  r.status = list_place(list_row.size(), val);
			CMD_INSERT_AT:  r.status = list_place(int'(pos), val);
			CMD_POP_FRONT: begin
				if (list_row.size() == 0)
					r.status = ST_EMPTY;
				else
					r.item = list_row.pop_front();
			end
			CMD_READ_AT: begin
				if (int'(pos) >= list_row.size())
					r.status = ST_RANGE;
				else
					r.item = list_row[pos];
			end
			CMD_MIN_MAX: begin
				if (list_row.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.max_item = list_row[0];
					r.min_item = list_row[0];
					foreach (list_row[i]) begin
						if (list_row[i] > r.max_item)
							r.max_item = list_row[i];
						if (list_row[i] < r.min_item)
							r.min_item = list_row[i];
					end
				end
			end
			default: ;
		endcase
		r.fill = 5'(list_row.size());
		return r;
	endfunction

	// Offer one command, hold it until the transfer, then record what it should return.
	// Valid is left high so that a following item can follow without a gap.
	task automatic send_item(input logic [2:0] cmd, input logic [4:0] pos,
			input logic signed [31:0] val);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		position <= pos;
		value    <= val;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(list_apply(cmd, pos, val));
	endtask

	// Receiver side: stall at random unless in a steady stretch.
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// Compare every result transfer with the oldest expectation.
	always @(posedge clk) begin
		list_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: status %0d item %0d fill %0d",
						status, item_out, fill_count);
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status || item_out !== exp_r.item ||
						largest !== exp_r.max_item || smallest !== exp_r.min_item ||
						fill_count !== exp_r.fill) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display({"result mismatch: exp status %0d item %0d max %0d min %0d",
							" fill %0d, got status %0d item %0d max %0d min %0d fill %0d"},
							exp_r.status, exp_r.item, exp_r.max_item, exp_r.min_item,
							exp_r.fill, status, item_out, largest, smallest, fill_count);
				end
			end
		end
	end

	// Give up on a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(15))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return 32'sh0000_0000;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_command(int mix);
		int r;
		r = $urandom_range(99);
		if (r >= 96)
			return r[0] ? CMD_SPARE_7 : CMD_SPARE_6;
		case (mix)
			MIX_FILL: begin
				if (r < 30) return CMD_PUSH_BACK;
				if (r < 45) return CMD_PUSH_FRONT;
				if (r < 65) return CMD_INSERT_AT;
				if (r < 76) return CMD_READ_AT;
				if (r < 86) return CMD_MIN_MAX;
				return CMD_POP_FRONT;
			end
			MIX_DRAIN: begin
				if (r < 45) return CMD_POP_FRONT;
				if (r < 60) return CMD_READ_AT;
				if (r < 70) return CMD_MIN_MAX;
				if (r < 80) return CMD_PUSH_BACK;
				if (r < 86) return CMD_PUSH_FRONT;
				return CMD_INSERT_AT;
			end
			default: begin
				if (r < 16) return CMD_PUSH_BACK;
				if (r < 32) return CMD_PUSH_FRONT;
				if (r < 48) return CMD_INSERT_AT;
				if (r < 64) return CMD_POP_FRONT;
				if (r < 80) return CMD_READ_AT;
				return CMD_MIN_MAX;
			end
		endcase
	endfunction

	// Mostly a position that hits the list, sometimes anything the field can carry.
	function automatic logic [4:0] pick_position(logic [2:0] cmd);
		int fill;
		fill = list_row.size();
		if ($urandom_range(99) < 15)
			return 5'($urandom_range(31));
		if (cmd == CMD_INSERT_AT)
			return 5'($urandom_range(fill, 0));
		if (fill > 0)
			return 5'($urandom_range(fill - 1, 0));
		return '0;
	endfunction

	// Commands on an empty list and codes the block does not decode.
	task automatic test_empty_list();
		send_item(CMD_POP_FRONT, 5'd0, 32'sd0);
		send_item(CMD_MIN_MAX, 5'd0, 32'sd0);
		send_item(CMD_READ_AT, 5'd0, 32'sd0);
		send_item(CMD_READ_AT, 5'd31, 32'sd0);
		send_item(CMD_INSERT_AT, 5'd1, 32'sd5);
		send_item(CMD_SPARE_6, 5'd0, 32'sd9);
		send_item(CMD_SPARE_7, 5'd31, -32'sd9);
	endtask

	// Pushes, inserts at the front, middle and end, reads and pops with extreme values.
	task automatic test_edit_ops();
		send_item(CMD_PUSH_BACK, 5'd0, 32'sh7FFF_FFFF);
		send_item(CMD_PUSH_FRONT, 5'd0, 32'sh8000_0000);
		send_item(CMD_INSERT_AT, 5'd1, -32'sd1);
		send_item(CMD_INSERT_AT, 5'd3, 32'sd0);
		send_item(CMD_INSERT_AT, 5'd5, 32'sd7);
		send_item(CMD_INSERT_AT, 5'd0, 32'sd123);
		send_item(CMD_READ_AT, 5'd0, 32'sd0);
		send_item(CMD_READ_AT, 5'd2, 32'sd0);
		send_item(CMD_READ_AT, 5'd4, 32'sd0);
		send_item(CMD_READ_AT, 5'd5, 32'sd0);
		send_item(CMD_MIN_MAX, 5'd0, 32'sd0);
		send_item(CMD_SPARE_7, 5'd2, 32'sd1);
		send_item(CMD_POP_FRONT, 5'd0, 32'sd0);
		send_item(CMD_POP_FRONT, 5'd0, 32'sd0);
		send_item(CMD_MIN_MAX, 5'd0, 32'sd0);
	endtask

	// Random traffic in fill, drain and even phases so the list swings between empty and full.
	task automatic test_random_traffic();
		int mix;
		logic [2:0] cmd;
		mix = MIX_FILL;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0)
				mix = (n == 0) ? MIX_FILL : $urandom_range(2);
			steady <= (n >= 600 && n < 800);
			cmd = pick_command(mix);
			send_item(cmd, pick_position(cmd), pick_value());
		end
		steady <= 1'b0;
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		command     = '0;
		position    = '0;
		value       = '0;
		out_ready   = 1'b0;
		steady      = 1'b0;
		mismatches  = 0;
		cycle_count = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_edit_ops();
		test_random_traffic();

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
